// ===== hw/rtl/drf_pkg.sv =====
// Shared types, codes and sizes for the byte ring message deframer.
`default_nettype none
package drf_pkg;

  localparam int unsigned RING_BYTES_DEF = 4096;
  localparam int unsigned SCAN_LIMIT_DEF = 256;
  localparam int unsigned HDR_BYTES      = 2;

  localparam logic [1:0] CMD_APPEND  = 2'd0;
  localparam logic [1:0] CMD_EXTRACT = 2'd1;
  localparam logic [1:0] CMD_RESYNC  = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NEED     = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_REJECTED = 2'd3;

  localparam logic [1:0] REG_QUOTE_TYPE = 2'd0;
  localparam logic [1:0] REG_QUOTE_SIZE = 2'd1;
  localparam logic [1:0] REG_TRADE_TYPE = 2'd2;
  localparam logic [1:0] REG_TRADE_SIZE = 2'd3;

  // Ring update applied when a pending result is delivered.
  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_CONSUME = 2'd1,
    ACT_DROP    = 2'd2
  } drf_act_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_HW   = 9'b000000010,
    S_HT   = 9'b000000100,
    S_HCHK = 9'b000001000,
    S_BW   = 9'b000010000,
    S_BT   = 9'b000100000,
    S_RW   = 9'b001000000,
    S_RT   = 9'b010000000,
    S_EMIT = 9'b100000000
  } drf_state_t;

  typedef struct packed {
    logic accept;
    logic hdr_take;
    logic hdr_check;
    logic body_take;
    logic scan_take;
    logic emit;
  } drf_cmd_t;

  typedef struct packed {
    logic direct;
    logic is_extract;
    logic hdr_second;
    logic go_body;
    logic flush;
    logic scan_first;
    logic scan_found;
    logic scan_more;
    logic out_free;
    logic res_last;
  } drf_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/drf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module drf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/drf_ctrl.sv =====
// Sequencing state machine for the deframer.
`default_nettype none
module drf_ctrl import drf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire drf_sts_t sts,
  output drf_cmd_t      cmd
);
  drf_state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = !sts.out_free;
        if (in_valid && sts.out_free) begin
          cmd.accept = 1'b1;
          if (!sts.direct) begin
            state_nxt = sts.is_extract ? S_HW : S_RW;
          end
        end
      end
      S_HW: state_nxt = S_HT;
      S_HT: begin
        cmd.hdr_take = 1'b1;
        state_nxt = sts.hdr_second ? S_HCHK : S_HW;
      end
      S_HCHK: begin
        cmd.hdr_check = 1'b1;
        state_nxt = sts.go_body ? S_BW : S_EMIT;
      end
      S_BW: state_nxt = S_BT;
      S_BT: begin
        cmd.body_take = 1'b1;
        state_nxt = sts.flush ? S_EMIT : S_BW;
      end
      S_RW: state_nxt = S_RT;
      S_RT: begin
        cmd.scan_take = 1'b1;
        if (sts.scan_first || (!sts.scan_found && sts.scan_more)) begin
          state_nxt = S_RW;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_nxt = sts.res_last ? S_IDLE : S_BW;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/drf_dp.sv =====
// Datapath: ring pointers, byte store, header and body registers, result register.
`default_nettype none
module drf_dp import drf_pkg::*; #(
  parameter int unsigned RING_BYTES = RING_BYTES_DEF,
  parameter int unsigned SCAN_LIMIT = SCAN_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_chunk_start,
  input  wire logic [12:0] in_chunk_length,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [7:0]       out_msg_type,
  output logic [7:0]       out_msg_length,
  output logic [63:0]      out_body_word,
  output logic [3:0]       out_word_bytes,
  output logic [8:0]       out_skip_count,
  output logic [12:0]      out_bytes_used,
  output logic [12:0]      out_space_free,
  output logic             out_last,
  input  wire drf_cmd_t    cmd,
  output drf_sts_t         sts
);
  localparam int unsigned AW = $clog2(RING_BYTES);
  localparam int unsigned CW = AW + 1;

  logic [7:0] qtype_r, qsize_r, ttype_r, tsize_r;
  logic [AW-1:0] rp_r, rp_nxt, wp_r, wp_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          rej_r, rej_nxt;

  logic [AW-1:0] off_r;
  logic [CW-1:0] limit_r;
  logic [7:0]    len_r, type_r, prev_r, cnt_r;
  logic [63:0]   word_r;
  logic [3:0]    nb_r;
  logic [1:0]    res_status_r;
  logic [8:0]    skip_r;
  logic          res_last_r;
  drf_act_t      act_r;

  logic [7:0]    rdata;
  logic          ram_we;
  logic          direct, accept_direct;
  logic          rej_start, app_ok;
  logic [1:0]    dir_status;
  logic [31:0]   total32;
  logic          plaus_hdr, plaus_scan, enough, body_last;
  logic [31:0]   off_m1, off_p1;
  logic          out_valid_r;

  function automatic logic plausible(input logic [7:0] len, input logic [7:0] typ,
                                     input logic [7:0] qt, input logic [7:0] qs,
                                     input logic [7:0] tt, input logic [7:0] ts);
    return (typ == qt && len == qs) || (typ == tt && len == ts);
  endfunction

  drf_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_data_byte),
    .raddr (AW'(rp_r + off_r)),
    .rdata (rdata)
  );

  // config port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qtype_r <= '0;
      qsize_r <= '0;
      ttype_r <= '0;
      tsize_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_QUOTE_TYPE: qtype_r <= pwdata[7:0];
        REG_QUOTE_SIZE: qsize_r <= pwdata[7:0];
        REG_TRADE_TYPE: ttype_r <= pwdata[7:0];
        REG_TRADE_SIZE: tsize_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_QUOTE_TYPE: prdata = {24'd0, qtype_r};
      REG_QUOTE_SIZE: prdata = {24'd0, qsize_r};
      REG_TRADE_TYPE: prdata = {24'd0, ttype_r};
      REG_TRADE_SIZE: prdata = {24'd0, tsize_r};
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    direct = (in_command == CMD_APPEND) || (in_command == CMD_CLEAR) ||
             (in_command == CMD_EXTRACT && 32'(fill_r) < HDR_BYTES) ||
             (in_command == CMD_RESYNC && 32'(fill_r) < HDR_BYTES + 1);
    accept_direct = cmd.accept && direct;
    rej_start = 32'(in_chunk_length) > (RING_BYTES - 32'(fill_r));
    rej_nxt   = rej_r;
    if (accept_direct && in_command == CMD_APPEND && in_chunk_start) begin
      rej_nxt = rej_start;
    end
    app_ok = !rej_nxt && (32'(fill_r) < RING_BYTES);
    ram_we = accept_direct && in_command == CMD_APPEND && app_ok;

    total32    = 32'(len_r) + HDR_BYTES;
    plaus_hdr  = plausible(len_r, type_r, qtype_r, qsize_r, ttype_r, tsize_r);
    plaus_scan = plausible(prev_r, rdata, qtype_r, qsize_r, ttype_r, tsize_r);
    enough     = 32'(fill_r) >= total32;
    body_last  = (9'(cnt_r) + 9'd1) == 9'(len_r);
    off_m1     = 32'(off_r) - 32'd1;
    off_p1     = 32'(off_r) + 32'd1;

    rp_nxt   = rp_r;
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    dir_status = ST_OK;
    if (accept_direct) begin
      case (in_command)
        CMD_APPEND: begin
          dir_status = app_ok ? ST_OK : ST_REJECTED;
          if (app_ok) begin
            wp_nxt   = AW'(wp_r + 1'b1);
            fill_nxt = CW'(fill_r + 1'b1);
          end
        end
        CMD_CLEAR: begin
          rp_nxt   = '0;
          wp_nxt   = '0;
          fill_nxt = '0;
        end
        default: dir_status = ST_NEED;
      endcase
    end else if (cmd.emit) begin
      case (act_r)
        ACT_CONSUME: begin
          rp_nxt   = AW'(32'(rp_r) + total32);
          fill_nxt = CW'(32'(fill_r) - total32);
        end
        ACT_DROP: begin
          rp_nxt   = AW'(rp_r + limit_r[AW-1:0]);
          fill_nxt = CW'(fill_r - limit_r);
        end
        default: ;
      endcase
    end

    sts.direct     = direct;
    sts.is_extract = in_command == CMD_EXTRACT;
    sts.hdr_second = off_r != '0;
    sts.go_body    = plaus_hdr && enough && len_r != 8'd0;
    sts.flush      = nb_r == 4'd7 || body_last;
    sts.scan_first = 32'(off_r) == 32'd1;
    sts.scan_found = plaus_scan;
    sts.scan_more  = off_p1 < 32'(limit_r);
    sts.out_free   = !out_valid_r || !out_stall;
    sts.res_last   = res_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r   <= '0;
      wp_r   <= '0;
      fill_r <= '0;
      rej_r  <= 1'b0;
    end else begin
      rp_r   <= rp_nxt;
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
      rej_r  <= rej_nxt;
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (cmd.accept && !direct) begin
      off_r        <= (in_command == CMD_EXTRACT) ? AW'(0) : AW'(1);
      limit_r      <= (32'(fill_r) < SCAN_LIMIT) ? fill_r : CW'(SCAN_LIMIT);
      word_r       <= '0;
      nb_r         <= '0;
      cnt_r        <= '0;
      skip_r       <= '0;
      res_status_r <= ST_OK;
      res_last_r   <= 1'b1;
      act_r        <= ACT_NONE;
    end
    if (cmd.hdr_take) begin
      if (off_r == '0) begin
        len_r <= rdata;
        off_r <= AW'(1);
      end else begin
        type_r <= rdata;
      end
    end
    if (cmd.hdr_check) begin
      res_last_r <= 1'b1;
      if (!plaus_hdr) begin
        res_status_r <= ST_INVALID;
      end else if (!enough) begin
        res_status_r <= ST_NEED;
      end else if (len_r == 8'd0) begin
        act_r <= ACT_CONSUME;
      end else begin
        off_r <= AW'(HDR_BYTES);
      end
    end
    if (cmd.body_take) begin
      word_r[8*nb_r[2:0] +: 8] <= rdata;
      nb_r  <= nb_r + 4'd1;
      cnt_r <= cnt_r + 8'd1;
      off_r <= AW'(off_p1);
      res_last_r <= body_last;
      act_r      <= body_last ? ACT_CONSUME : ACT_NONE;
    end
    if (cmd.scan_take) begin
      if (sts.scan_first) begin
        prev_r <= rdata;
        off_r  <= AW'(off_p1);
      end else if (plaus_scan) begin
        res_status_r <= ST_OK;
        type_r <= rdata;
        len_r  <= prev_r;
        skip_r <= off_m1[8:0];
      end else if (sts.scan_more) begin
        prev_r <= rdata;
        off_r  <= AW'(off_p1);
      end else begin
        res_status_r <= ST_INVALID;
        type_r <= '0;
        len_r  <= '0;
        skip_r <= 9'(32'(limit_r));
        act_r  <= ACT_DROP;
      end
    end
    if (cmd.emit) begin
      word_r <= '0;
      nb_r   <= '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept_direct || cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_direct) begin
      out_status     <= dir_status;
      out_msg_type   <= '0;
      out_msg_length <= '0;
      out_body_word  <= '0;
      out_word_bytes <= '0;
      out_skip_count <= (in_command == CMD_RESYNC) ? 9'(32'(fill_r)) : 9'd0;
      out_last       <= 1'b1;
    end else if (cmd.emit) begin
      out_status     <= res_status_r;
      out_msg_type   <= type_r;
      out_msg_length <= len_r;
      out_body_word  <= word_r;
      out_word_bytes <= nb_r;
      out_skip_count <= skip_r;
      out_last       <= res_last_r;
    end
    if (accept_direct || cmd.emit) begin
      out_bytes_used <= 13'(32'(fill_nxt));
      out_space_free <= 13'(RING_BYTES - 32'(fill_nxt));
    end
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

// ===== hw/rtl/byte_ring_message_deframer.sv =====
// Top level of the byte ring message deframer.
`default_nettype none
// A byte ring of RING_BYTES entries holds a stream of length/type framed
// messages. Append, clear, and an extract or resync that finds too few bytes
// complete without leaving the idle state, so appended bytes stream at one per
// cycle while the result channel keeps up. An extract walks the ring through
// the single read port of the byte store, with a wait and a take state for
// each header and body byte and an emit state per result word. A resync reads
// at most SCAN_LIMIT bytes, with a wait and a take state for each. Only one
// command is in flight at a time; a new transaction is taken no earlier than
// the cycle in which the result register frees up, so a stalled result holds
// off the input. A chunk is accepted or rejected whole on its first byte.
// The byte store has no reset; the ring never reads unwritten entries.
module byte_ring_message_deframer import drf_pkg::*; #(
  parameter int unsigned RING_BYTES = RING_BYTES_DEF,
  parameter int unsigned SCAN_LIMIT = SCAN_LIMIT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_command,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_chunk_start,
  input  wire logic [12:0] in_chunk_length,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [7:0]       out_msg_type,
  output logic [7:0]       out_msg_length,
  output logic [63:0]      out_body_word,
  output logic [3:0]       out_word_bytes,
  output logic [8:0]       out_skip_count,
  output logic [12:0]      out_bytes_used,
  output logic [12:0]      out_space_free,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  drf_cmd_t cmd;
  drf_sts_t sts;

  // zero wait states on the register port
  assign pready = 1'b1;

  // controller: sequence header, body and scan walks
  drf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: hold the ring, advance pointers, build results
  drf_dp #(.RING_BYTES(RING_BYTES), .SCAN_LIMIT(SCAN_LIMIT)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_command),
    .in_data_byte    (in_data_byte),
    .in_chunk_start  (in_chunk_start),
    .in_chunk_length (in_chunk_length),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_msg_type    (out_msg_type),
    .out_msg_length  (out_msg_length),
    .out_body_word   (out_body_word),
    .out_word_bytes  (out_word_bytes),
    .out_skip_count  (out_skip_count),
    .out_bytes_used  (out_bytes_used),
    .out_space_free  (out_space_free),
    .out_last        (out_last),
    .cmd             (cmd),
    .sts             (sts)
  );

`ifndef SYNTHESIS
  // a walking command blocks further transactions until it finishes
  a_walk_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !sts.direct) |=> in_stall)
    else $error("transaction taken during a ring walk");

  // a result is only loaded when the result register is free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result loaded over a pending result");

  // occupancy and free space of a valid result add up to the ring size (rings under 8192 bytes)
  a_space_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && RING_BYTES < 8192) |->
      (32'(out_bytes_used) + 32'(out_space_free) == RING_BYTES))
    else $error("bytes_used and space_free disagree");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/byte_ring_message_deframer_tb.sv =====
// Self-checking testbench for the byte ring message deframer.
`default_nettype none
module byte_ring_message_deframer_tb import drf_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING = 4096;
  localparam int SCAN = 256;

  // One input transaction; pinned rows carry a status typed into the table.
  typedef struct {
    logic [1:0]  cmd;
    logic [7:0]  data;
    logic        start;
    logic [12:0] clen;
    logic        pinned;
    logic [1:0]  pin_st;
  } frame_op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  msg_type;
    logic [7:0]  msg_length;
    logic [63:0] body_word;
    logic [3:0]  word_bytes;
    logic [8:0]  skip_count;
    logic [12:0] bytes_used;
    logic [12:0] space_free;
    logic        last;
  } deframe_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_command = CMD_APPEND;
  logic [7:0] in_data_byte = '0;
  logic in_chunk_start = 1'b0;
  logic [12:0] in_chunk_length = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_msg_type, out_msg_length;
  logic [63:0] out_body_word;
  logic [3:0] out_word_bytes;
  logic [8:0] out_skip_count;
  logic [12:0] out_bytes_used, out_space_free;
  logic out_last;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  byte_ring_message_deframer i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the ring and the header registers.
  logic [7:0]  ring_shadow [RING];
  logic [11:0] rd_ptr, wr_ptr;
  int          fill_bytes;
  logic        rejecting;
  logic [7:0]  q_code, q_len, t_code, t_len;

  deframe_res_t result_q[$];
  frame_op_t    pending_ops[$];
  frame_op_t    sent_ops[$];
  int           mismatches = 0;
  logic         calm = 1'b0;     // no idling on either side while set
  logic         hold_kick = 1'b0;
  logic         hold_done = 1'b0;
  int           hold_left = 0;

  function automatic logic header_ok(logic [7:0] len, logic [7:0] typ);
    return (typ == q_code && len == q_len) || (typ == t_code && len == t_len);
  endfunction

  function automatic deframe_res_t pack_res(logic [1:0] st, logic [7:0] typ, logic [7:0] len,
                                            logic [63:0] word, int nb, int skip, logic lst);
    deframe_res_t r;
    r.status = st;
    r.msg_type = typ;
    r.msg_length = len;
    r.body_word = word;
    r.word_bytes = 4'(nb);
    r.skip_count = 9'(skip);
    r.bytes_used = 13'(fill_bytes);
    r.space_free = 13'(RING - fill_bytes);
    r.last = lst;
    return r;
  endfunction

  // Advance the shadow ring by one transaction and queue what it must produce.
  task automatic forecast(frame_op_t op);
    logic [7:0] len, typ;
    logic [63:0] word;
    logic hit;
    int total, nres, n, limit, first;
    hit = 1'b0;
    first = result_q.size();
    case (op.cmd)
      CMD_APPEND: begin
        if (op.start) rejecting = int'(op.clen) > RING - fill_bytes;
        hit = !rejecting && fill_bytes < RING;
        if (hit) begin
          ring_shadow[wr_ptr] = op.data;
          wr_ptr++;
          fill_bytes++;
        end
        result_q.push_back(pack_res(hit ? ST_OK : ST_REJECTED, 0, 0, 0, 0, 0, 1'b1));
      end
      CMD_EXTRACT: begin
        if (fill_bytes < 2) begin
          result_q.push_back(pack_res(ST_NEED, 0, 0, 0, 0, 0, 1'b1));
        end else begin
          len = ring_shadow[rd_ptr];
          typ = ring_shadow[12'(rd_ptr + 1)];
          total = 2 + int'(len);
          if (!header_ok(len, typ)) begin
            result_q.push_back(pack_res(ST_INVALID, typ, len, 0, 0, 0, 1'b1));
          end else if (fill_bytes < total) begin
            result_q.push_back(pack_res(ST_NEED, typ, len, 0, 0, 0, 1'b1));
          end else begin
            nres = (len == 0) ? 1 : (int'(len) + 7) / 8;
            for (int k = 0; k < nres; k++) begin
              word = '0;
              n = (int'(len) - 8 * k > 8) ? 8 : int'(len) - 8 * k;
              for (int b = 0; b < n; b++)
                word[8*b +: 8] = ring_shadow[12'(rd_ptr + 2 + 8 * k + b)];
              if (k + 1 == nres) begin
                rd_ptr = 12'(rd_ptr + total);
                fill_bytes -= total;
              end
              result_q.push_back(pack_res(ST_OK, typ, len, word, n, 0, k + 1 == nres));
            end
          end
        end
      end
      CMD_RESYNC: begin
        if (fill_bytes < 3) begin
          result_q.push_back(pack_res(ST_NEED, 0, 0, 0, 0, fill_bytes, 1'b1));
        end else begin
          limit = (fill_bytes < SCAN) ? fill_bytes : SCAN;
          for (int i = 1; i + 1 < limit && !hit; i++) begin
            len = ring_shadow[12'(rd_ptr + i)];
            typ = ring_shadow[12'(rd_ptr + i + 1)];
            if (header_ok(len, typ)) begin
              hit = 1'b1;
              result_q.push_back(pack_res(ST_OK, typ, len, 0, 0, i, 1'b1));
            end
          end
          if (!hit) begin
            rd_ptr = 12'(rd_ptr + limit);
            fill_bytes -= limit;
            result_q.push_back(pack_res(ST_INVALID, 0, 0, 0, 0, limit, 1'b1));
          end
        end
      end
      default: begin
        rd_ptr = '0;
        wr_ptr = '0;
        fill_bytes = 0;
        result_q.push_back(pack_res(ST_OK, 0, 0, 0, 0, 0, 1'b1));
      end
    endcase
    // A pinned table row overrides the status of its first result.
    if (op.pinned) result_q[first].status = op.pin_st;
  endtask

  // Check results first: a result taken at this edge belongs to an older transaction.
  always @(posedge clk) begin
    deframe_res_t got, want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_status, out_msg_type, out_msg_length, out_body_word, out_word_bytes,
                out_skip_count, out_bytes_used, out_space_free, out_last};
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %p", got);
        end else begin
          want = result_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
          end
        end
      end
      if (in_valid && !in_stall) forecast(sent_ops.pop_front());
    end
  end

  // Receiver: random stall, one long hold-off on request, none while calm.
  always @(posedge clk) begin
    if (hold_kick && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 600;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 25);
    end
  end

  function automatic frame_op_t op_of(logic [1:0] cmd, logic [7:0] data, logic start,
                                      logic [12:0] clen);
    frame_op_t op;
    op = '{cmd, data, start, clen, 1'b0, ST_OK};
    return op;
  endfunction

  function automatic frame_op_t pin(frame_op_t op, logic [1:0] st);
    op.pinned = 1'b1;
    op.pin_st = st;
    return op;
  endfunction

  // Directed table: header/body extremes, reject, zero-length chunk, every command.
  frame_op_t directed [] = '{
    pin(op_of(CMD_EXTRACT, 8'h00, 1'b0, 13'd0), ST_NEED),
    pin(op_of(CMD_RESYNC, 8'h00, 1'b0, 13'd0), ST_NEED),
    pin(op_of(CMD_APPEND, 8'h00, 1'b1, 13'd2), ST_OK),
    pin(op_of(CMD_APPEND, 8'h54, 1'b0, 13'd0), ST_OK),
    pin(op_of(CMD_EXTRACT, 8'h00, 1'b0, 13'd0), ST_OK),
    pin(op_of(CMD_APPEND, 8'hFF, 1'b1, 13'h1FFF), ST_REJECTED),
    pin(op_of(CMD_APPEND, 8'h12, 1'b0, 13'h1FFF), ST_REJECTED),
    pin(op_of(CMD_APPEND, 8'hFF, 1'b1, 13'd0), ST_OK),
    pin(op_of(CMD_EXTRACT, 8'h00, 1'b0, 13'd0), ST_NEED),
    pin(op_of(CMD_APPEND, 8'h04, 1'b1, 13'd3), ST_OK),
    pin(op_of(CMD_APPEND, 8'h51, 1'b0, 13'd0), ST_OK),
    pin(op_of(CMD_APPEND, 8'h01, 1'b0, 13'd0), ST_OK),
    pin(op_of(CMD_EXTRACT, 8'h00, 1'b0, 13'd0), ST_INVALID),
    pin(op_of(CMD_RESYNC, 8'h00, 1'b0, 13'd0), ST_OK),
    pin(op_of(CMD_EXTRACT, 8'h00, 1'b0, 13'd0), ST_INVALID),
    pin(op_of(CMD_CLEAR, 8'h00, 1'b0, 13'd0), ST_OK),
    pin(op_of(CMD_APPEND, 8'h04, 1'b1, 13'd6), ST_OK),
    pin(op_of(CMD_APPEND, 8'h51, 1'b0, 13'd0), ST_OK),
    pin(op_of(CMD_APPEND, 8'hA5, 1'b0, 13'd0), ST_OK),
    pin(op_of(CMD_EXTRACT, 8'h00, 1'b0, 13'd0), ST_NEED),
    op_of(CMD_APPEND, 8'h5A, 1'b0, 13'd0),
    op_of(CMD_APPEND, 8'h00, 1'b0, 13'd0),
    op_of(CMD_APPEND, 8'hFF, 1'b0, 13'd0),
    op_of(CMD_EXTRACT, 8'h00, 1'b0, 13'd0),
    pin(op_of(CMD_RESYNC, 8'h00, 1'b0, 13'd0), ST_NEED)
  };

  // Drive one transaction; hold it until taken, idling at random beforehand.
  task automatic offer(frame_op_t op);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= op.cmd;
    in_data_byte <= op.data;
    in_chunk_start <= op.start;
    in_chunk_length <= op.clen;
    sent_ops.push_back(op);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic flush_ops();
    while (pending_ops.size() > 0) offer(pending_ops.pop_front());
    in_valid <= 1'b0;
  endtask

  // Wait for every expected result, then give a long extract time to settle.
  task automatic drain();
    while (result_q.size() > 0 || sent_ops.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_QUOTE_TYPE: q_code = value;
      REG_QUOTE_SIZE: q_len = value;
      REG_TRADE_TYPE: t_code = value;
      default: t_len = value;
    endcase
  endtask

  task automatic load_headers(logic [7:0] qt, logic [7:0] qs, logic [7:0] tt, logic [7:0] ts);
    write_reg(REG_QUOTE_TYPE, qt);
    write_reg(REG_QUOTE_SIZE, qs);
    write_reg(REG_TRADE_TYPE, tt);
    write_reg(REG_TRADE_SIZE, ts);
  endtask

  // Queue random traffic: mostly framed messages as chunks, the rest noise.
  task automatic build_traffic(int count);
    logic [7:0] len, typ;
    int total;
    repeat (count) begin
      if ($urandom_range(0, 99) < 70) begin
        if ($urandom_range(0, 1)) begin
          len = q_len;
          typ = q_code;
        end else begin
          len = t_len;
          typ = t_code;
        end
        total = 2 + int'(len);
        pending_ops.push_back(op_of(CMD_APPEND, len, 1'b1,
          ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 8191)) : 13'(total)));
        pending_ops.push_back(op_of(CMD_APPEND, typ, 1'b0, 13'($urandom)));
        for (int i = 0; i < int'(len); i++)
          pending_ops.push_back(op_of(CMD_APPEND, 8'($urandom), 1'b0, 13'($urandom)));
        if ($urandom_range(0, 99) < 80)
          pending_ops.push_back(op_of(CMD_EXTRACT, 8'($urandom), 1'b0, 13'($urandom)));
      end else begin
        pending_ops.push_back(op_of(2'($urandom), 8'($urandom), ($urandom_range(0, 2) == 0),
                                    13'($urandom_range(0, 8191))));
      end
    end
  endtask

  initial begin
    int room;
    rd_ptr = '0;
    wr_ptr = '0;
    fill_bytes = 0;
    rejecting = 1'b0;
    {q_code, q_len, t_code, t_len} = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_headers(8'h51, 8'd4, 8'h54, 8'd0);
    foreach (directed[i]) pending_ops.push_back(directed[i]);
    flush_ops();
    drain();

    // Multi-word bodies first, then random settings with small bodies.
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) load_headers(8'hFF, 8'd17, 8'h00, 8'd0);
      else if (phase == 1) load_headers(8'h00, 8'd16, 8'hFF, 8'd8);
      else load_headers(8'($urandom), 8'($urandom_range(0, 12)),
                        8'($urandom), 8'($urandom_range(0, 12)));
      calm = (phase == 3);
      hold_kick = (phase == 4);
      build_traffic(phase == 0 ? 6 : (phase == 1 ? 5 : 7));
      flush_ops();
      drain();
      pending_ops.push_back(op_of(CMD_CLEAR, 8'h00, 1'b0, 13'd0));
      flush_ops();
      drain();
    end
    calm = 1'b0;

    // Offer a chunk one byte larger than the free space, then one that just fits.
    load_headers(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    pending_ops.push_back(op_of(CMD_APPEND, 8'h07, 1'b1, 13'd5));
    pending_ops.push_back(op_of(CMD_EXTRACT, 8'h00, 1'b0, 13'd0));
    pending_ops.push_back(op_of(CMD_RESYNC, 8'h00, 1'b0, 13'd0));
    flush_ops();
    drain();
    room = RING - fill_bytes;
    pending_ops.push_back(op_of(CMD_APPEND, 8'($urandom), 1'b1, 13'(room + 1)));
    pending_ops.push_back(op_of(CMD_APPEND, 8'($urandom), 1'b0, 13'($urandom)));
    pending_ops.push_back(op_of(CMD_APPEND, 8'($urandom), 1'b1, 13'(room)));
    pending_ops.push_back(op_of(CMD_RESYNC, 8'h00, 1'b0, 13'd0));
    pending_ops.push_back(op_of(CMD_EXTRACT, 8'h00, 1'b0, 13'd0));
    pending_ops.push_back(op_of(CMD_CLEAR, 8'h00, 1'b0, 13'd0));
    flush_ops();
    drain();

    if (mismatches == 0) begin
      $display("PASS byte_ring_message_deframer");
    end else begin
      $display("FAIL byte_ring_message_deframer");
    end
    $finish;
  end

  // Timeout far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("FAIL byte_ring_message_deframer");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/drf_pkg.sv
hw/rtl/drf_ram.sv
hw/rtl/drf_ctrl.sv
hw/rtl/drf_dp.sv
hw/rtl/byte_ring_message_deframer.sv
tb/sv/byte_ring_message_deframer_tb.sv
